// ===== rtl/bcp_pkg.sv =====
`default_nettype none

package bcp_pkg;

    // letters buffered per group (cipher period)
    localparam int GROUP_SIZE = 5;

    localparam int SIDE      = 5;
    localparam int CODE_W    = 5;
    localparam int COORD_W   = 3;
    localparam int CNT_W     = $clog2(GROUP_SIZE + 1);
    localparam int IDX_W     = $clog2(GROUP_SIZE);
    localparam int POS_W     = $clog2(2 * GROUP_SIZE);

    // square packing in the configuration words
    localparam int SQ_WORD_W     = 60;
    localparam int SQ_WORD_CELLS = 12;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CODE_W-1:0] LETTER_J = 5'd9;
    localparam logic [CODE_W-1:0] LETTER_I = 5'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SQUARE_FIRST,
        CFG_SQUARE_SECOND,
        CFG_SQUARE_FINAL,
        CFG_CIPHER_MODE
    } t_cfg_reg;

    typedef enum logic {
        MODE_ENCRYPT,
        MODE_DECRYPT
    } t_mode;

    typedef logic [CODE_W-1:0]  t_code;
    typedef logic [COORD_W-1:0] t_coord;

    typedef t_code [SIDE-1:0]   t_sq_row;
    typedef t_sq_row [SIDE-1:0] t_square;

    typedef struct packed {
        t_coord row;
        t_coord col;
    } t_cell_pos;

    typedef t_coord [GROUP_SIZE-1:0] t_coord_vec;
    typedef t_code [GROUP_SIZE-1:0]  t_letters;

    // one complete group handed to the mixer
    typedef struct packed {
        t_coord_vec       rows;
        t_coord_vec       cols;
        logic [CNT_W-1:0] count;
    } t_group;

endpackage

`default_nettype wire

// ===== rtl/bcp_if.sv =====
`default_nettype none

interface bcp_in_if;
    logic           valid;
    logic           ready;
    bcp_pkg::t_code letter_in;
    logic           end_of_message;

    modport source (output valid, output letter_in, output end_of_message, input ready);
    modport sink   (input valid, input letter_in, input end_of_message, output ready);
endinterface

interface bcp_out_if;
    logic           valid;
    logic           ready;
    bcp_pkg::t_code letter_out;
    logic           group_last;

    modport source (output valid, output letter_out, output group_last, input ready);
    modport sink   (input valid, input letter_out, input group_last, output ready);
endinterface

interface bcp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bcp_pkg::CFG_IDX_W-1:0]    index;
    logic [bcp_pkg::SQ_WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bcp_lookup.sv =====
`default_nettype none

module bcp_lookup (
    input  wire bcp_pkg::t_code     i_code,
    input  wire bcp_pkg::t_square   i_square,
    output bcp_pkg::t_cell_pos      o_pos
);

    bcp_pkg::t_code code_eff;

    // j folds onto i; lowest matching cell wins, no match gives (0,0)
    always_comb begin
        code_eff  = (i_code == bcp_pkg::LETTER_J) ? bcp_pkg::LETTER_I : i_code;
        o_pos.row = '0;
        o_pos.col = '0;
        for (int r = bcp_pkg::SIDE - 1; r >= 0; r--) begin
            for (int c = bcp_pkg::SIDE - 1; c >= 0; c--) begin
                if (i_square[r][c] == code_eff) begin
                    o_pos.row = bcp_pkg::COORD_W'(r);
                    o_pos.col = bcp_pkg::COORD_W'(c);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bcp_mixer.sv =====
`default_nettype none

module bcp_mixer (
    input  wire bcp_pkg::t_group    i_group,
    input  wire bcp_pkg::t_mode     i_mode,
    input  wire bcp_pkg::t_square   i_square,
    output bcp_pkg::t_letters       o_letters
);

    // element pos of the combined row/column sequence
    function automatic bcp_pkg::t_coord seq_at(
        input bcp_pkg::t_group          g,
        input bcp_pkg::t_mode           mode,
        input logic [bcp_pkg::POS_W-1:0] pos
    );
        logic [bcp_pkg::POS_W-1:0] n_ext;
        logic [bcp_pkg::POS_W-1:0] off;
        bcp_pkg::t_coord           val;
        n_ext = bcp_pkg::POS_W'(g.count);
        if (mode == bcp_pkg::MODE_ENCRYPT) begin
            // all rows, then all columns
            if (pos < n_ext) begin
                val = g.rows[pos[bcp_pkg::IDX_W-1:0]];
            end else begin
                off = pos - n_ext;
                val = g.cols[off[bcp_pkg::IDX_W-1:0]];
            end
        end else begin
            // row and column interleaved per letter
            off = pos >> 1;
            val = pos[0] ? g.cols[off[bcp_pkg::IDX_W-1:0]]
                         : g.rows[off[bcp_pkg::IDX_W-1:0]];
        end
        return val;
    endfunction

    always_comb begin
        bcp_pkg::t_coord r;
        bcp_pkg::t_coord c;
        for (int i = 0; i < bcp_pkg::GROUP_SIZE; i++) begin
            if (i_mode == bcp_pkg::MODE_ENCRYPT) begin
                r = seq_at(i_group, i_mode, bcp_pkg::POS_W'(2 * i));
                c = seq_at(i_group, i_mode, bcp_pkg::POS_W'(2 * i + 1));
            end else begin
                r = seq_at(i_group, i_mode, bcp_pkg::POS_W'(i));
                c = seq_at(i_group, i_mode,
                           bcp_pkg::POS_W'(i) + bcp_pkg::POS_W'(i_group.count));
            end
            o_letters[i] = i_square[r][c];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bifid_cipher_period5_top.sv =====
`default_nettype none

// bifid cipher over a keyed 5x5 square, period 5
// channels (valid/ready, a word moves when both are high at a rising edge):
//   i_in  : one letter code per word plus an end-of-message flag
//   o_out : one cipher letter per word, group_last on the final one of a group
//   i_cfg : register writes (0 square cells 0-11, 1 cells 12-23, 2 cell 24,
//           3 mode), always ready; write only while the block is idle
// a word is registered, looked up in the square from that register and its
// row/column stored; when a group of five fills or end_of_message arrives,
// the whole group is mixed into a five-entry output buffer
// the word that closes a group passes the input register and the group
// buffer before the group is loaded; letters then leave one per cycle
// while o_out is ready; i_in takes one word per cycle for full groups;
// the output buffer holds one group, so a group that closes while the
// previous one is still draining waits, and back-pressure reaches i_in.ready
// stall on o_out holds the current letter stable and freezes the pipeline
// once the buffer is needed
// reset (synchronous, active low) empties the pipeline, the group count and
// the output buffer and clears the square and the mode to zero
module bifid_cipher_period5_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bcp_in_if.sink      i_in,
    bcp_out_if.source   o_out,
    bcp_cfg_if.sink     i_cfg
);

    // configuration registers
    logic [bcp_pkg::SQ_WORD_W-1:0] r_square_first;
    logic [bcp_pkg::SQ_WORD_W-1:0] r_square_second;
    bcp_pkg::t_code                r_square_final;
    bcp_pkg::t_mode                r_mode;
    bcp_pkg::t_square              square;

    // input register
    logic                   r_in_v;
    bcp_pkg::t_code         r_in_code;
    logic                   r_in_eom;

    // group buffer
    bcp_pkg::t_coord_vec    r_rows;
    bcp_pkg::t_coord_vec    r_cols;
    logic [bcp_pkg::CNT_W-1:0] r_fill;
    logic                   r_done_v;
    logic [bcp_pkg::CNT_W-1:0] r_done_n;

    // output buffer
    logic                   r_emit_v;
    bcp_pkg::t_letters      r_emit_letters;
    logic [bcp_pkg::CNT_W-1:0] r_emit_n;
    logic [bcp_pkg::CNT_W-1:0] r_emit_idx;

    bcp_pkg::t_cell_pos     pos;
    bcp_pkg::t_group        group;
    bcp_pkg::t_letters      mixed;
    logic [bcp_pkg::CNT_W-1:0] fill_inc;
    logic                   closes;
    logic                   emit_last;
    logic                   emit_take;
    logic                   emit_free;
    logic                   load;
    logic                   adv;
    logic                   in_ready;

    // unpack cells into a row/column view of the square
    always_comb begin
        for (int r = 0; r < bcp_pkg::SIDE; r++) begin
            for (int c = 0; c < bcp_pkg::SIDE; c++) begin
                if (r * bcp_pkg::SIDE + c < bcp_pkg::SQ_WORD_CELLS) begin
                    square[r][c] =
                        r_square_first[(r * bcp_pkg::SIDE + c) * bcp_pkg::CODE_W +:
                                       bcp_pkg::CODE_W];
                end else if (r * bcp_pkg::SIDE + c < 2 * bcp_pkg::SQ_WORD_CELLS) begin
                    square[r][c] =
                        r_square_second[(r * bcp_pkg::SIDE + c - bcp_pkg::SQ_WORD_CELLS)
                                        * bcp_pkg::CODE_W +: bcp_pkg::CODE_W];
                end else begin
                    square[r][c] = r_square_final;
                end
            end
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square_first  <= '0;
            r_square_second <= '0;
            r_square_final  <= '0;
            r_mode          <= bcp_pkg::MODE_ENCRYPT;
        end else if (i_cfg.valid) begin
            unique case (bcp_pkg::t_cfg_reg'(i_cfg.index))
                bcp_pkg::CFG_SQUARE_FIRST:  r_square_first  <= i_cfg.data;
                bcp_pkg::CFG_SQUARE_SECOND: r_square_second <= i_cfg.data;
                bcp_pkg::CFG_SQUARE_FINAL:  r_square_final  <= i_cfg.data[bcp_pkg::CODE_W-1:0];
                bcp_pkg::CFG_CIPHER_MODE:   r_mode          <= bcp_pkg::t_mode'(i_cfg.data[0]);
                default: ;
            endcase
        end
    end

    // letter to row/column
    bcp_lookup u_lookup (
        .i_code   (r_in_code),
        .i_square (square),
        .o_pos    (pos)
    );

    // whole group to output letters
    assign group.rows  = r_rows;
    assign group.cols  = r_cols;
    assign group.count = r_done_n;

    bcp_mixer u_mixer (
        .i_group   (group),
        .i_mode    (r_mode),
        .i_square  (square),
        .o_letters (mixed)
    );

    // handshake and flow control
    assign emit_last = (bcp_pkg::CNT_W'(r_emit_idx + bcp_pkg::CNT_W'(1)) == r_emit_n);
    assign emit_take = r_emit_v && o_out.ready;
    assign emit_free = !r_emit_v || (emit_take && emit_last);
    assign load      = r_done_v && emit_free;
    assign adv       = !r_done_v || load;
    assign in_ready  = !r_in_v || adv;
    assign fill_inc  = bcp_pkg::CNT_W'(r_fill + bcp_pkg::CNT_W'(1));
    assign closes    = (fill_inc == bcp_pkg::CNT_W'(bcp_pkg::GROUP_SIZE)) || r_in_eom;

    assign i_in.ready = in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_ready) begin
            r_in_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_code <= i_in.letter_in;
            r_in_eom  <= i_in.end_of_message;
        end
    end

    // group buffer: store coordinates, flag a closed group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_done_v <= 1'b0;
        end else if (adv) begin
            r_done_v <= r_in_v && closes;
            if (r_in_v) begin
                r_fill <= closes ? '0 : fill_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_v) begin
            r_rows[r_fill[bcp_pkg::IDX_W-1:0]] <= pos.row;
            r_cols[r_fill[bcp_pkg::IDX_W-1:0]] <= pos.col;
            r_done_n                           <= fill_inc;
        end
    end

    // output buffer: one group, drained a letter per cycle while o_out is ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_v   <= 1'b0;
            r_emit_idx <= '0;
        end else if (load) begin
            r_emit_v   <= 1'b1;
            r_emit_idx <= '0;
        end else if (emit_take) begin
            if (emit_last) begin
                r_emit_v <= 1'b0;
            end
            r_emit_idx <= bcp_pkg::CNT_W'(r_emit_idx + bcp_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_emit_letters <= mixed;
            r_emit_n       <= r_done_n;
        end
    end

    assign o_out.valid      = r_emit_v;
    assign o_out.letter_out = r_emit_letters[r_emit_idx[bcp_pkg::IDX_W-1:0]];
    assign o_out.group_last = emit_last;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int CELLS         = bcp_pkg::SIDE * bcp_pkg::SIDE;
    localparam int RANDOM_ITEMS  = 380;
    // leave room for a closing word to pass the pipeline, and more
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400_000;

    // one letter the block owes us
    typedef struct packed {
        bcp_pkg::t_code letter;
        logic           last;
    } t_cipher_letter;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bcp_in_if  in_if ();
    bcp_out_if out_if ();
    bcp_cfg_if cfg_if ();

    bifid_cipher_period5_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #4 i_clk = ~i_clk;

    // cipher state as the block should hold it
    bcp_pkg::t_code  sq_cells [CELLS];
    bcp_pkg::t_mode  cur_mode;
    bcp_pkg::t_coord grp_rows [bcp_pkg::GROUP_SIZE];
    bcp_pkg::t_coord grp_cols [bcp_pkg::GROUP_SIZE];
    int              grp_fill;

    // letters predicted but not yet seen on o_out
    t_cipher_letter pending_letters [$];

    // square to be loaded by the next configuration pass
    bcp_pkg::t_code staged_sq [CELLS];

    // both sides draw random gaps only while this is set
    bit idling_on = 1'b1;

    int          mismatches  = 0;
    int unsigned cycle_count = 0;

    // ------------------------------------------------------------------
    // cipher model
    // ------------------------------------------------------------------

    // first cell holding the code, j folded onto i; absent letters land on 0
    function automatic int find_cell(input bcp_pkg::t_code code);
        bcp_pkg::t_code key;
        key = (code == bcp_pkg::LETTER_J) ? bcp_pkg::LETTER_I : code;
        for (int k = 0; k < CELLS; k++) begin
            if (sq_cells[k] == key) return k;
        end
        return 0;
    endfunction

    // store one letter's coordinates; a full group or end of message emits
    function automatic void bifid_take_letter(input bcp_pkg::t_code code, input logic eom);
        int              cell_idx;
        int              n;
        bcp_pkg::t_coord seq [2*bcp_pkg::GROUP_SIZE];
        bcp_pkg::t_coord r;
        bcp_pkg::t_coord c;
        t_cipher_letter  owed;
        cell_idx = find_cell(code);
        if (grp_fill >= bcp_pkg::GROUP_SIZE) grp_fill = 0;
        grp_rows[grp_fill] = bcp_pkg::t_coord'(cell_idx / bcp_pkg::SIDE);
        grp_cols[grp_fill] = bcp_pkg::t_coord'(cell_idx % bcp_pkg::SIDE);
        grp_fill++;
        if (grp_fill < bcp_pkg::GROUP_SIZE && !eom) return;

        n = grp_fill;
        for (int i = 0; i < n; i++) begin
            if (cur_mode == bcp_pkg::MODE_ENCRYPT) begin
                // all rows first, then all columns
                seq[i]     = grp_rows[i];
                seq[n + i] = grp_cols[i];
            end else begin
                // row and column interleaved per letter
                seq[2*i]     = grp_rows[i];
                seq[2*i + 1] = grp_cols[i];
            end
        end
        for (int i = 0; i < n; i++) begin
            if (cur_mode == bcp_pkg::MODE_ENCRYPT) begin
                r = seq[2*i];
                c = seq[2*i + 1];
            end else begin
                r = seq[i];
                c = seq[i + n];
            end
            owed.letter     = sq_cells[r*bcp_pkg::SIDE + c];
            owed.last       = (i == n - 1);
            pending_letters = {pending_letters, owed};
        end
        grp_fill = 0;
    endfunction

    function automatic void apply_reg(input bcp_pkg::t_cfg_reg idx,
                                      input logic [bcp_pkg::SQ_WORD_W-1:0] value);
        case (idx)
            bcp_pkg::CFG_SQUARE_FIRST: begin
                for (int k = 0; k < bcp_pkg::SQ_WORD_CELLS; k++)
                    sq_cells[k] = value[bcp_pkg::CODE_W*k +: bcp_pkg::CODE_W];
            end
            bcp_pkg::CFG_SQUARE_SECOND: begin
                for (int k = 0; k < bcp_pkg::SQ_WORD_CELLS; k++)
                    sq_cells[bcp_pkg::SQ_WORD_CELLS + k] =
                        value[bcp_pkg::CODE_W*k +: bcp_pkg::CODE_W];
            end
            bcp_pkg::CFG_SQUARE_FINAL: sq_cells[CELLS-1] = value[bcp_pkg::CODE_W-1:0];
            bcp_pkg::CFG_CIPHER_MODE:  cur_mode = bcp_pkg::t_mode'(value[0]);
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // square builders
    // ------------------------------------------------------------------

    // the 25 letters without j, alphabetic or shuffled
    function automatic void make_keyed_square(input bit shuffle);
        bcp_pkg::t_code pool [CELLS];
        bcp_pkg::t_code tmp;
        int             n;
        int             j;
        n = 0;
        for (int c = 0; c < 26; c++) begin
            if (c != bcp_pkg::LETTER_J) begin
                pool[n] = bcp_pkg::t_code'(c);
                n++;
            end
        end
        if (shuffle) begin
            for (int k = CELLS - 1; k > 0; k--) begin
                j = $urandom_range(0, k);
                tmp = pool[k];
                pool[k] = pool[j];
                pool[j] = tmp;
            end
        end
        staged_sq = pool;
    endfunction

    // any 5-bit code per cell: duplicates, gaps and codes past z
    function automatic void make_noise_square();
        for (int k = 0; k < CELLS; k++) staged_sq[k] = bcp_pkg::t_code'($urandom_range(0, 31));
    endfunction

    function automatic void make_uniform_square(input bcp_pkg::t_code code);
        for (int k = 0; k < CELLS; k++) staged_sq[k] = code;
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // one word on i_in; valid stays high afterwards for a back-to-back word
    task automatic send_letter(input bcp_pkg::t_code code, input logic eom);
        int gap;
        gap = idling_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.letter_in      <= code;
        in_if.end_of_message <= eom;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        bifid_take_letter(code, eom);
    endtask

    // drop valid, let every owed letter drain and the pipeline settle
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_letters.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write; valid is left high for a following write
    task automatic cfg_put(input bcp_pkg::t_cfg_reg idx,
                           input logic [bcp_pkg::SQ_WORD_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        apply_reg(idx, value);
    endtask

    // staged square plus mode, all four registers
    task automatic load_config(input bcp_pkg::t_mode m);
        logic [bcp_pkg::SQ_WORD_W-1:0] first_w;
        logic [bcp_pkg::SQ_WORD_W-1:0] second_w;
        first_w  = '0;
        second_w = '0;
        for (int k = 0; k < bcp_pkg::SQ_WORD_CELLS; k++) begin
            first_w[bcp_pkg::CODE_W*k +: bcp_pkg::CODE_W]  = staged_sq[k];
            second_w[bcp_pkg::CODE_W*k +: bcp_pkg::CODE_W] =
                staged_sq[bcp_pkg::SQ_WORD_CELLS + k];
        end
        cfg_put(bcp_pkg::CFG_SQUARE_FIRST, first_w);
        cfg_put(bcp_pkg::CFG_SQUARE_SECOND, second_w);
        cfg_put(bcp_pkg::CFG_SQUARE_FINAL, bcp_pkg::SQ_WORD_W'(staged_sq[CELLS-1]));
        cfg_put(bcp_pkg::CFG_CIPHER_MODE, bcp_pkg::SQ_WORD_W'(m));
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_mode(input bcp_pkg::t_mode m);
        cfg_put(bcp_pkg::CFG_CIPHER_MODE, bcp_pkg::SQ_WORD_W'(m));
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls, every accepted word checked in order
    // ------------------------------------------------------------------
    initial begin
        int             stall;
        t_cipher_letter exp_letter;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = idling_on ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            if (pending_letters.size() == 0) begin
                $error("unexpected word: letter_out %0d group_last %0d",
                       out_if.letter_out, out_if.group_last);
                mismatches++;
            end else begin
                exp_letter = pending_letters.pop_front();
                if (out_if.letter_out !== exp_letter.letter) begin
                    $error("letter_out expected %0d actual %0d",
                           exp_letter.letter, out_if.letter_out);
                    mismatches++;
                end
                if (out_if.group_last !== exp_letter.last) begin
                    $error("group_last expected %0d actual %0d",
                           exp_letter.last, out_if.group_last);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // square all zero after reset: every letter maps to cell 0, code 0
    task automatic test_reset_state();
        send_letter(bcp_pkg::t_code'(0), 1'b0);
        send_letter(bcp_pkg::LETTER_J, 1'b0);
        send_letter(bcp_pkg::t_code'(25), 1'b1);
        wait_idle();
    endtask

    // alphabetic square, a full group closed by count, then a one-letter message
    task automatic test_encrypt_groups();
        make_keyed_square(1'b0);
        load_config(bcp_pkg::MODE_ENCRYPT);
        send_letter(bcp_pkg::t_code'(5), 1'b0);
        send_letter(bcp_pkg::t_code'(11), 1'b0);
        send_letter(bcp_pkg::t_code'(4), 1'b0);
        send_letter(bcp_pkg::LETTER_J, 1'b0);
        send_letter(bcp_pkg::t_code'(25), 1'b0);
        send_letter(bcp_pkg::t_code'(0), 1'b1);
        wait_idle();
    endtask

    // same square, short decrypt group, no idling on either side
    task automatic test_decrypt_groups();
        idling_on = 1'b0;
        set_mode(bcp_pkg::MODE_DECRYPT);
        send_letter(bcp_pkg::t_code'(19), 1'b0);
        send_letter(bcp_pkg::LETTER_J, 1'b0);
        send_letter(bcp_pkg::t_code'(25), 1'b1);
        wait_idle();
        idling_on = 1'b1;
    endtask

    // codes past z in the square and at the input, repeated codes, a missing letter
    task automatic test_square_corners();
        for (int k = 0; k < CELLS; k++)
            staged_sq[k] = (k < 6) ? bcp_pkg::t_code'(31 - k) : bcp_pkg::t_code'(k % 4);
        load_config(bcp_pkg::MODE_ENCRYPT);
        send_letter(bcp_pkg::t_code'(27), 1'b0);
        send_letter(bcp_pkg::t_code'(31), 1'b0);
        send_letter(bcp_pkg::t_code'(3), 1'b0);
        send_letter(bcp_pkg::t_code'(20), 1'b1);
        wait_idle();
    endtask

    // mode flips while a group is half full: the mode at emission rules
    task automatic test_mode_switch_mid_group();
        make_keyed_square(1'b1);
        load_config(bcp_pkg::MODE_ENCRYPT);
        send_letter(bcp_pkg::t_code'($urandom_range(0, 25)), 1'b0);
        send_letter(bcp_pkg::t_code'($urandom_range(0, 25)), 1'b0);
        wait_idle();
        set_mode(bcp_pkg::MODE_DECRYPT);
        send_letter(bcp_pkg::t_code'($urandom_range(0, 25)), 1'b1);
        wait_idle();
    endtask

    // random messages over mostly keyed squares, some noise and extreme squares
    task automatic test_random_messages();
        int sent;
        int len;
        int kind;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == 0 || $urandom_range(0, 3) == 0) begin
                wait_idle();
                kind = $urandom_range(0, 9);
                if (kind <= 6) make_keyed_square(1'b1);
                else if (kind == 7) make_noise_square();
                else if (kind == 8) make_uniform_square(bcp_pkg::t_code'(31));
                else make_uniform_square(bcp_pkg::t_code'(0));
                load_config(bcp_pkg::t_mode'($urandom_range(0, 1)));
            end
            // some messages run with both sides at full rate
            idling_on = ($urandom_range(0, 3) != 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                // now and then flip the mode inside a message
                if (i == len / 2 && i > 0 && $urandom_range(0, 11) == 0) begin
                    wait_idle();
                    set_mode(bcp_pkg::t_mode'($urandom_range(0, 1)));
                end
                send_letter(bcp_pkg::t_code'($urandom_range(0, 25)), i == len - 1);
                sent++;
            end
        end
        idling_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        in_if.valid          <= 1'b0;
        in_if.letter_in      <= '0;
        in_if.end_of_message <= 1'b0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= bcp_pkg::CFG_SQUARE_FIRST;
        cfg_if.data          <= '0;

        // model state after reset
        for (int k = 0; k < CELLS; k++) sq_cells[k] = '0;
        cur_mode = bcp_pkg::MODE_ENCRYPT;
        grp_fill = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_encrypt_groups();
        test_decrypt_groups();
        test_square_corners();
        test_mode_switch_mid_group();
        test_random_messages();

        wait_idle();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
